// ----- hw/rtl/hlbt_pkg.sv -----
// shared types and constants of the hilbert transpose converter
package hlbt_pkg;

  localparam int NUM_WORDS  = 8;
  localparam int WORD_W     = 32;
  localparam int DIMS_REG_W = 4;
  localparam int BITS_REG_W = 6;
  localparam int CFG_DATA_W = 6;

  localparam logic [DIMS_REG_W-1:0] DIMS_RESET = 4'd3;
  localparam logic [BITS_REG_W-1:0] BITS_RESET = 6'd16;

  // configuration register indexes
  typedef enum logic {
    REG_DIMS = 1'b0,
    REG_BITS = 1'b1
  } reg_index_t;

  // conversion direction
  typedef enum logic {
    ACT_TO_AXES  = 1'b0,
    ACT_TO_INDEX = 1'b1
  } act_t;

  // control that travels alongside each beat's words
  typedef struct packed {
    logic valid;
    act_t action;
  } tag_t;

endpackage

// ----- hw/rtl/hlbt_front.sv -----
// input stage: mask to the curve order and gray decode for the to-axes direction
module hlbt_front #(
  parameter int MAX_DIMS = 8,
  parameter int MAX_BITS = 32,
  parameter int DIM_W    = 3
) (
  input  logic                               clk,
  input  logic                               rst,
  input  hlbt_pkg::tag_t                     tag_in,
  input  logic [MAX_DIMS-1:0][MAX_BITS-1:0]  words_in,
  input  logic [MAX_DIMS-1:0]                dim_en,
  input  logic [MAX_BITS-1:0]                word_mask,
  input  logic [DIM_W-1:0]                   last_dim,
  output hlbt_pkg::tag_t                     tag_out,
  output logic [MAX_DIMS-1:0][MAX_BITS-1:0]  words_out
);
  import hlbt_pkg::*;

  logic [MAX_DIMS-1:0][MAX_BITS-1:0] masked;
  logic [MAX_DIMS-1:0][MAX_BITS-1:0] decoded;
  logic [MAX_DIMS-1:0][MAX_BITS-1:0] words_next;
  logic [MAX_BITS-1:0]               top_word;

  always_comb begin
    for (int i = 0; i < MAX_DIMS; i++) begin
      masked[i] = dim_en[i] ? (words_in[i] & word_mask) : '0;
    end
    top_word   = masked[last_dim];
    decoded[0] = masked[0] ^ (top_word >> 1);
    for (int i = 1; i < MAX_DIMS; i++) begin
      decoded[i] = dim_en[i] ? (masked[i] ^ masked[i-1]) : '0;
    end
    case (tag_in.action)
      ACT_TO_AXES:  words_next = decoded;
      ACT_TO_INDEX: words_next = masked;
      default:      words_next = masked;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    words_out <= words_next;
  end

endmodule

// ----- hw/rtl/hlbt_level.sv -----
// one excess-work level: a sweep of swap or invert steps over all enabled dimensions
module hlbt_level #(
  parameter int MAX_DIMS = 8,
  parameter int MAX_BITS = 32,
  parameter int BW       = 6,
  parameter int LEVEL    = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  hlbt_pkg::tag_t                     tag_in,
  input  logic [MAX_DIMS-1:0][MAX_BITS-1:0]  words_in,
  input  logic [MAX_DIMS-1:0]                dim_en,
  input  logic [BW-1:0]                      bits_eff,
  output hlbt_pkg::tag_t                     tag_out,
  output logic [MAX_DIMS-1:0][MAX_BITS-1:0]  words_out
);
  import hlbt_pkg::*;

  // to-axes walks q upwards, to-index walks it downwards
  localparam int FQ_RAW = LEVEL + 1;
  localparam int FQ     = (FQ_RAW < MAX_BITS) ? FQ_RAW : MAX_BITS - 1;
  localparam int IQ     = (MAX_BITS - 1 - LEVEL > 0) ? MAX_BITS - 1 - LEVEL : 0;
  localparam bit IQ_OK  = (IQ >= 1);
  localparam logic [MAX_BITS-1:0] PF = MAX_BITS'((64'd1 << FQ) - 64'd1);
  localparam logic [MAX_BITS-1:0] PI = MAX_BITS'((64'd1 << IQ) - 64'd1);

  logic [MAX_DIMS-1:0][MAX_BITS-1:0] wf;
  logic [MAX_DIMS-1:0][MAX_BITS-1:0] wi;
  logic [MAX_DIMS-1:0][MAX_BITS-1:0] words_next;
  logic [MAX_BITS-1:0]               tf;
  logic [MAX_BITS-1:0]               ti;
  logic                              fwd_on;
  logic                              inv_on;

  assign fwd_on = (bits_eff > BW'(FQ_RAW));
  assign inv_on = IQ_OK && (bits_eff > BW'(IQ));

  always_comb begin
    tf = '0;
    ti = '0;
    // to-axes: last dimension first
    wf = words_in;
    for (int k = MAX_DIMS - 1; k >= 0; k--) begin
      if (dim_en[k]) begin
        if (wf[k][FQ]) begin
          wf[0] = wf[0] ^ PF;
        end else begin
          tf    = (wf[0] ^ wf[k]) & PF;
          wf[0] = wf[0] ^ tf;
          wf[k] = wf[k] ^ tf;
        end
      end
    end
    // to-index: first dimension first
    wi = words_in;
    for (int k = 0; k < MAX_DIMS; k++) begin
      if (dim_en[k]) begin
        if (wi[k][IQ]) begin
          wi[0] = wi[0] ^ PI;
        end else begin
          ti    = (wi[0] ^ wi[k]) & PI;
          wi[0] = wi[0] ^ ti;
          wi[k] = wi[k] ^ ti;
        end
      end
    end
    case (tag_in.action)
      ACT_TO_AXES:  words_next = fwd_on ? wf : words_in;
      ACT_TO_INDEX: words_next = inv_on ? wi : words_in;
      default:      words_next = words_in;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    words_out <= words_next;
  end

endmodule

// ----- hw/rtl/hlbt_back.sv -----
// output stages: gray encode for the to-index direction, final mask
module hlbt_back #(
  parameter int MAX_DIMS = 8,
  parameter int MAX_BITS = 32,
  parameter int DIM_W    = 3
) (
  input  logic                               clk,
  input  logic                               rst,
  input  hlbt_pkg::tag_t                     tag_in,
  input  logic [MAX_DIMS-1:0][MAX_BITS-1:0]  words_in,
  input  logic [MAX_DIMS-1:0]                dim_en,
  input  logic [MAX_BITS-1:0]                word_mask,
  input  logic [DIM_W-1:0]                   last_dim,
  output hlbt_pkg::tag_t                     tag_out,
  output logic [MAX_DIMS-1:0][MAX_BITS-1:0]  words_out
);
  import hlbt_pkg::*;

  tag_t                              tag_a;
  logic [MAX_DIMS-1:0][MAX_BITS-1:0] words_a;
  logic [MAX_DIMS-1:0][MAX_BITS-1:0] words_a_next;
  logic [MAX_DIMS-1:0][MAX_BITS-1:0] words_out_next;
  logic [MAX_DIMS-1:0][MAX_BITS-1:0] prefix;
  logic [MAX_BITS-1:0]               acc;
  logic [MAX_BITS-1:0]               last_word;
  logic [MAX_BITS-1:0]               fix;

  // running xor across the dimensions
  always_comb begin
    acc = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      acc       = acc ^ words_in[i];
      prefix[i] = dim_en[i] ? acc : '0;
    end
    case (tag_in.action)
      ACT_TO_AXES:  words_a_next = words_in;
      ACT_TO_INDEX: words_a_next = prefix;
      default:      words_a_next = words_in;
    endcase
  end

  // each bit of the correction is the parity of the last word above it
  always_comb begin
    last_word = words_a[last_dim];
    for (int k = 0; k < MAX_BITS; k++) begin
      fix[k] = ^(last_word >> (k + 1));
    end
    for (int i = 0; i < MAX_DIMS; i++) begin
      case (tag_a.action)
        ACT_TO_AXES:  words_out_next[i] = words_a[i] & word_mask;
        ACT_TO_INDEX: words_out_next[i] = (words_a[i] ^ fix) & word_mask;
        default:      words_out_next[i] = words_a[i] & word_mask;
      endcase
      if (!dim_en[i]) begin
        words_out_next[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a   <= '0;
      tag_out <= '0;
    end else begin
      tag_a   <= tag_in;
      tag_out <= tag_a;
    end
  end

  always_ff @(posedge clk) begin
    words_a   <= words_a_next;
    words_out <= words_out_next;
  end

endmodule

// ----- hw/rtl/hilbert_transpose_converter_core.sv -----
// an accepted beat passes the front stage, the level stages and the back stages in that order before done rises
// throughput: one beat per cycle outside reset, set by one excess-work level per pipeline stage
// busy is high only while rst is high; done may be high every cycle and cannot be held off
// reset clears every stage valid flag and sets 3 dimensions and 16 bits in use
// a beat accepted at the edge after a register write already uses the new setting
module hilbert_transpose_converter_core #(
  parameter int MAX_DIMS = 8,
  parameter int MAX_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  output logic                            done,
  input  logic                            action,
  input  logic [hlbt_pkg::WORD_W-1:0]     in_word_0,
  input  logic [hlbt_pkg::WORD_W-1:0]     in_word_1,
  input  logic [hlbt_pkg::WORD_W-1:0]     in_word_2,
  input  logic [hlbt_pkg::WORD_W-1:0]     in_word_3,
  input  logic [hlbt_pkg::WORD_W-1:0]     in_word_4,
  input  logic [hlbt_pkg::WORD_W-1:0]     in_word_5,
  input  logic [hlbt_pkg::WORD_W-1:0]     in_word_6,
  input  logic [hlbt_pkg::WORD_W-1:0]     in_word_7,
  output logic [hlbt_pkg::WORD_W-1:0]     out_word_0,
  output logic [hlbt_pkg::WORD_W-1:0]     out_word_1,
  output logic [hlbt_pkg::WORD_W-1:0]     out_word_2,
  output logic [hlbt_pkg::WORD_W-1:0]     out_word_3,
  output logic [hlbt_pkg::WORD_W-1:0]     out_word_4,
  output logic [hlbt_pkg::WORD_W-1:0]     out_word_5,
  output logic [hlbt_pkg::WORD_W-1:0]     out_word_6,
  output logic [hlbt_pkg::WORD_W-1:0]     out_word_7,
  input  logic                            cfg_write,
  input  logic                            cfg_index,
  input  logic [hlbt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hlbt_pkg::*;

  // widths that follow from the parameters
  localparam int DIM_W   = $clog2(MAX_DIMS);
  localparam int DW      = $clog2(MAX_DIMS + 1);
  localparam int BW      = $clog2(MAX_BITS + 1);
  localparam int NUM_LVL = (MAX_BITS > 1) ? MAX_BITS - 1 : 1;
  localparam int LAT     = NUM_LVL + 3;

  // configuration registers as written
  logic [DIMS_REG_W-1:0] dims_in_use;
  logic [BITS_REG_W-1:0] bits_in_use;

  // clamped controls, decoded straight from the registers
  logic [MAX_DIMS-1:0] dim_en;
  logic [DIM_W-1:0]    last_dim;
  logic [MAX_BITS-1:0] word_mask;
  logic [BW-1:0]       bits_eff;
  logic [DW-1:0]       dims_eff;

  // pipeline wiring
  tag_t                              tag_in;
  logic [NUM_WORDS-1:0][WORD_W-1:0]  in_all;
  logic [NUM_WORDS-1:0][WORD_W-1:0]  out_all;
  logic [MAX_DIMS-1:0][MAX_BITS-1:0] words_in;
  tag_t                              lvl_tag   [NUM_LVL+1];
  logic [MAX_DIMS-1:0][MAX_BITS-1:0] lvl_words [NUM_LVL+1];
  tag_t                              fin_tag;
  logic [MAX_DIMS-1:0][MAX_BITS-1:0] fin_words;

  // checks on the delivered beat
  logic unused_clear;
  logic in_range;

  // no flow control beyond reset: a beat can enter every cycle
  assign busy = rst;

  // register writes, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= DIMS_RESET;
      bits_in_use <= BITS_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_DIMS: dims_in_use <= cfg_data[DIMS_REG_W-1:0];
        REG_BITS: bits_in_use <= cfg_data[BITS_REG_W-1:0];
        default:  ;
      endcase
    end
  end

  // zero counts act as one, oversize counts saturate at the build limit
  always_comb begin
    if (dims_in_use == '0) begin
      dims_eff = DW'(1);
    end else if (dims_in_use > DIMS_REG_W'(MAX_DIMS)) begin
      dims_eff = DW'(MAX_DIMS);
    end else begin
      dims_eff = DW'(dims_in_use);
    end
    if (bits_in_use == '0) begin
      bits_eff = BW'(1);
    end else if (bits_in_use > BITS_REG_W'(MAX_BITS)) begin
      bits_eff = BW'(MAX_BITS);
    end else begin
      bits_eff = BW'(bits_in_use);
    end
    for (int i = 0; i < MAX_DIMS; i++) begin
      dim_en[i] = (DW'(i) < dims_eff);
    end
    last_dim = DIM_W'(dims_eff - DW'(1));
    for (int k = 0; k < MAX_BITS; k++) begin
      word_mask[k] = (BW'(k) < bits_eff);
    end
  end

  // gather the input words, words above the build limit are dropped
  assign in_all = {in_word_7, in_word_6, in_word_5, in_word_4,
                   in_word_3, in_word_2, in_word_1, in_word_0};

  always_comb begin
    for (int i = 0; i < MAX_DIMS; i++) begin
      words_in[i] = in_all[i][MAX_BITS-1:0];
    end
  end

  assign tag_in.valid  = start & ~busy;
  assign tag_in.action = act_t'(action);

  // stage 0: mask and gray decode
  hlbt_front #(
    .MAX_DIMS (MAX_DIMS),
    .MAX_BITS (MAX_BITS),
    .DIM_W    (DIM_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .tag_in    (tag_in),
    .words_in  (words_in),
    .dim_en    (dim_en),
    .word_mask (word_mask),
    .last_dim  (last_dim),
    .tag_out   (lvl_tag[0]),
    .words_out (lvl_words[0])
  );

  // one stage per bit level of the excess-work loop
  for (genvar g = 0; g < NUM_LVL; g++) begin : g_lvl
    hlbt_level #(
      .MAX_DIMS (MAX_DIMS),
      .MAX_BITS (MAX_BITS),
      .BW       (BW),
      .LEVEL    (g)
    ) u_level (
      .clk       (clk),
      .rst       (rst),
      .tag_in    (lvl_tag[g]),
      .words_in  (lvl_words[g]),
      .dim_en    (dim_en),
      .bits_eff  (bits_eff),
      .tag_out   (lvl_tag[g+1]),
      .words_out (lvl_words[g+1])
    );
  end

  // last two stages: prefix xor, then the gray-encode correction and output register
  hlbt_back #(
    .MAX_DIMS (MAX_DIMS),
    .MAX_BITS (MAX_BITS),
    .DIM_W    (DIM_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tag_in    (lvl_tag[NUM_LVL]),
    .words_in  (lvl_words[NUM_LVL]),
    .dim_en    (dim_en),
    .word_mask (word_mask),
    .last_dim  (last_dim),
    .tag_out   (fin_tag),
    .words_out (fin_words)
  );

  assign done = fin_tag.valid;

  // spread the result back onto the fixed output ports
  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      out_all[i] = '0;
    end
    for (int i = 0; i < MAX_DIMS; i++) begin
      out_all[i] = WORD_W'(fin_words[i]);
    end
  end

  assign out_word_0 = out_all[0];
  assign out_word_1 = out_all[1];
  assign out_word_2 = out_all[2];
  assign out_word_3 = out_all[3];
  assign out_word_4 = out_all[4];
  assign out_word_5 = out_all[5];
  assign out_word_6 = out_all[6];
  assign out_word_7 = out_all[7];

  always_comb begin
    unused_clear = 1'b1;
    in_range     = 1'b1;
    for (int i = 0; i < MAX_DIMS; i++) begin
      if (!dim_en[i] && (fin_words[i] != '0)) begin
        unused_clear = 1'b0;
      end
      if ((fin_words[i] & ~word_mask) != '0) begin
        in_range = 1'b0;
      end
    end
  end

  // a result beat only ever follows an accepted beat by the full latency
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start & ~busy, LAT))
    else $error("done without a matching start");

  // dimensions outside the active set read as zero
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    done |-> unused_clear)
    else $error("unused dimension word not zero");

  // every result word stays below two to the curve order
  a_word_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> in_range)
    else $error("result word above the curve order");

  // the input side is never held off outside reset
  a_never_busy: assert property (@(posedge clk)
    !rst |-> !busy)
    else $error("busy outside reset");

endmodule
